FILE: rtl/calendar_clock_tick_assert.svh
// Assertion macros for the calendar clock tick block.
// Included by modules that check their own logic; no other dependencies.
`ifndef CALENDAR_CLOCK_TICK_ASSERT_SVH
`define CALENDAR_CLOCK_TICK_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define CCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: rtl/cct_pkg.sv
// Shared types and constants for the calendar clock tick block.
// No dependencies.
package cct_pkg;

	localparam int unsigned TDATA_W = 48;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [1:0]  mode;
	} time_t;

	typedef struct packed {
		time_t tm;
		logic  error;
	} result_t;

	// item kind carried on tuser
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// hour modes
	localparam logic [1:0] MODE_AM = 2'd0;
	localparam logic [1:0] MODE_PM = 2'd1;
	localparam logic [1:0] MODE_24 = 2'd2;

	localparam logic [5:0]  SEC_LAST    = 6'd59;
	localparam logic [5:0]  MIN_LAST    = 6'd59;
	localparam logic [4:0]  HOUR_LAST24 = 5'd23;
	localparam logic [4:0]  HOUR_LASTAM = 5'd11;
	localparam logic [4:0]  HOUR_LASTPM = 5'd12;
	localparam logic [4:0]  HOURS_DAY   = 5'd24;
	localparam logic [4:0]  HOUR_NOON   = 5'd12;
	localparam logic [4:0]  HOUR_PM_WRAP = 5'd13;
	localparam logic [3:0]  MONTH_LAST  = 4'd12;
	localparam logic [13:0] YEAR_LAST   = 14'd9999;

	localparam time_t TIME_RST = '{
		year:   14'd2022,
		month:  4'd1,
		day:    5'd1,
		hour:   5'd0,
		minute: 6'd0,
		second: 6'd0,
		mode:   MODE_24
	};

	function automatic logic [4:0] month_len(input logic [3:0] month, input logic [13:0] year);
		logic [4:0] len;
		case (month)
			4'd2:                    len = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

FILE: rtl/cct_step.sv
// Next-time logic: load, validity check and one-second advance with carries.
// Depends on cct_pkg.
module cct_step (
	input  cct_pkg::time_t cur,
	input  logic           op,
	input  cct_pkg::time_t load,
	output cct_pkg::time_t nxt,
	output logic           err
);

	logic [4:0] mlen;
	logic [4:0] hr_inc;
	logic       ok;
	logic       is_am;
	logic       is_pm;

	always_comb begin
		mlen   = cct_pkg::month_len(cur.month, cur.year);
		hr_inc = cur.hour + 5'd1;
		is_am  = (cur.mode == cct_pkg::MODE_AM);
		is_pm  = (cur.mode == cct_pkg::MODE_PM);
		ok = (cur.second <= cct_pkg::SEC_LAST) && (cur.minute <= cct_pkg::MIN_LAST)
			&& (cur.hour <= cct_pkg::HOUR_LAST24)
			&& (cur.mode == cct_pkg::MODE_AM || cur.mode == cct_pkg::MODE_PM
				|| cur.mode == cct_pkg::MODE_24)
			&& !(is_am && cur.hour > cct_pkg::HOUR_LASTAM)
			&& !(is_pm && cur.hour > cct_pkg::HOUR_LASTPM)
			&& (cur.month != 4'd0) && (cur.month <= cct_pkg::MONTH_LAST)
			&& (cur.day != 5'd0) && (cur.day <= mlen);
	end

	always_comb begin
		nxt = cur;
		err = 1'b0;
		if (op == cct_pkg::OP_LOAD) begin
			nxt = load;
		end else if (!ok) begin
			err = 1'b1;
		end else if (cur.second != cct_pkg::SEC_LAST) begin
			nxt.second = cur.second + 6'd1;
		end else begin
			nxt.second = 6'd0;
			if (cur.minute != cct_pkg::MIN_LAST) begin
				nxt.minute = cur.minute + 6'd1;
			end else begin
				nxt.minute = 6'd0;
				if (is_am && hr_inc >= cct_pkg::HOUR_NOON) begin
					nxt.mode = cct_pkg::MODE_PM;
					nxt.hour = hr_inc;
				end else if (is_pm && hr_inc >= cct_pkg::HOUR_PM_WRAP) begin
					nxt.hour = 5'd1;
				end else if (hr_inc >= cct_pkg::HOURS_DAY
						|| (is_pm && hr_inc >= cct_pkg::HOUR_NOON)) begin
					// midnight: 11 PM rolls to 0 AM, 23 rolls to 0
					if (is_pm)
						nxt.mode = cct_pkg::MODE_AM;
					nxt.hour = 5'd0;
					if (cur.day != mlen) begin
						nxt.day = cur.day + 5'd1;
					end else begin
						nxt.day = 5'd1;
						if (cur.month != cct_pkg::MONTH_LAST) begin
							nxt.month = cur.month + 4'd1;
						end else begin
							nxt.month = 4'd1;
							nxt.year = (cur.year >= cct_pkg::YEAR_LAST) ? 14'd0
								: cur.year + 14'd1;
						end
					end
				end else begin
					nxt.hour = hr_inc;
				end
			end
		end
	end

endmodule

FILE: rtl/cct_out_reg.sv
// Output register: holds one result until the receiver takes it.
// Depends on cct_pkg.
module cct_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cct_pkg::result_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output cct_pkg::result_t out_data
);

	logic             valid_q;
	cct_pkg::result_t data_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (in_ready)
			valid_q <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			data_q <= in_data;
	end

endmodule

FILE: rtl/calendar_clock_tick.sv
// Calendar clock tick top level: input stage, time registers, output register.
// Depends on cct_pkg, cct_step, cct_out_reg and calendar_clock_tick_assert.svh.
//
// Usage:
//  - Input stream (s_axis_*): tuser selects the item kind, tick (0) or load (1);
//    tdata carries the time to load, ignored on a tick.
//  - Output stream (m_axis_*): one result per input transaction, in order;
//    tdata is the stored time after the item, tuser is the error flag set
//    when a tick found the stored time invalid (the time is then unchanged).
//  - Pipeline: input stage then output register; m_axis_tvalid rises when
//    the output register takes the item's result from the input stage.
//  - Throughput: one item per cycle unless the receiver stalls. The time
//    registers are read and rewritten in the same cycle an item moves from
//    the input stage to the output register; consecutive items chain gap-free.
//  - Reset: 2022-01-01 00:00:00 in 24-hour mode, both stages empty.
//  - Receiver stall: the output register holds its result and the input
//    stage holds one more item; s_axis_tready drops only when both are full.
`include "calendar_clock_tick_assert.svh"

module calendar_clock_tick (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
	// second[39:34], mode[41:40], zero[47:42]
	input  logic [cct_pkg::TDATA_W-1:0]  s_axis_tdata,
	// op[0]
	input  logic                         s_axis_tuser,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// year_out[13:0], month_out[17:14], day_out[22:18], hour_out[27:23],
	// minute_out[33:28], second_out[39:34], mode_out[41:40], zero[47:42]
	output logic [cct_pkg::TDATA_W-1:0]  m_axis_tdata,
	// error[0]
	output logic                         m_axis_tuser
);

	logic             valid_s1;
	logic             op_s1;
	cct_pkg::time_t   load_s1;
	cct_pkg::time_t   cur_q;
	cct_pkg::time_t   nxt;
	logic             err;
	logic             out_in_ready;
	logic             adv;
	cct_pkg::result_t res;
	cct_pkg::result_t out_res;
	cct_pkg::time_t   in_tm;

	assign in_tm = '{
		year:   s_axis_tdata[13:0],
		month:  s_axis_tdata[17:14],
		day:    s_axis_tdata[22:18],
		hour:   s_axis_tdata[27:23],
		minute: s_axis_tdata[33:28],
		second: s_axis_tdata[39:34],
		mode:   s_axis_tdata[41:40]
	};

	// stage 1 moves on when the output register can take its result
	assign adv           = valid_s1 && out_in_ready;
	assign s_axis_tready = !valid_s1 || out_in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1   <= s_axis_tuser;
			load_s1 <= in_tm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cur_q <= cct_pkg::TIME_RST;
		else if (adv)
			cur_q <= nxt;
	end

	cct_step u_step (
		.cur  (cur_q),
		.op   (op_s1),
		.load (load_s1),
		.nxt  (nxt),
		.err  (err)
	);

	assign res = '{tm: nxt, error: err};

	cct_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_ready  (out_in_ready),
		.in_data   (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = {6'd0, out_res.tm.mode, out_res.tm.second, out_res.tm.minute,
		out_res.tm.hour, out_res.tm.day, out_res.tm.month, out_res.tm.year};
	assign m_axis_tuser = out_res.error;

	`CCT_ASSERT_NXT(a_state_hold, clk, arst_n, !adv, $stable(cur_q), "time changed without a transaction")
	`CCT_ASSERT_NXT(a_err_hold, clk, arst_n, adv && err, $stable(cur_q), "error tick changed the time")
	`CCT_ASSERT_NXT(a_load_no_err, clk, arst_n, adv && op_s1 == cct_pkg::OP_LOAD, !m_axis_tuser, "load reported an error")
	`CCT_ASSERT_IMP(a_out_matches, clk, arst_n, m_axis_tvalid, out_res.tm == cur_q, "pending result differs from stored time")
	`CCT_ASSERT_NXT(a_s1_hold, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(load_s1), "stage 1 item lost while stalled")

endmodule
